@@ rtl/sus_pkg.sv @@
// Shared types and constants for the sorted unique set.
// Holds the action codes, the fixed field widths and the result layout.
// No dependencies.
`default_nettype none

package sus_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 5;
    localparam int COUNT_W = 6;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_READ   = 2'd2
    } action_t;

    // Per-cell status handed back to the top level.
    typedef struct packed {
        logic ge;   // cell is at or beyond the insertion point
        logic eq;   // cell holds the key
    } cell_flags_t;

    // Result item, entry_value in the lowest bits.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               full_res;
        logic               duplicate;
        logic               inserted;
        logic               entry_valid;
        logic [VALUE_W-1:0] entry_value;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/sus_cell.sv @@
// One storage cell of the sorted chain.
// Compares its entry with the key and takes the key or its left neighbour's
// entry on an insert. Depends on sus_pkg.
`default_nettype none

module sus_cell #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  occupied,
    input  wire logic                  left_ge,
    input  wire logic [VALUE_BITS-1:0] left_val,
    input  wire logic [VALUE_BITS-1:0] key,
    input  wire logic                  shift_en,
    output logic      [VALUE_BITS-1:0] stored_val,
    output sus_pkg::cell_flags_t       flags
);

    logic [VALUE_BITS-1:0] stored_reg;
    logic [VALUE_BITS-1:0] stored_next;

    always_comb
    begin
        flags.ge = !(occupied && (stored_reg < key));
        flags.eq = occupied && (stored_reg == key);
    end

    // Cells past the insertion point move up by one; the cell at the
    // insertion point takes the key. Cells below it keep their entry.
    always_comb
    begin
        stored_next = stored_reg;
        if (shift_en)
        begin
            priority if (left_ge)
                stored_next = left_val;
            else if (flags.ge)
                stored_next = key;
            else
                stored_next = stored_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        stored_reg <= stored_next;
    end

    assign stored_val = stored_reg;

endmodule

`default_nettype wire

@@ rtl/sorted_unique_set_insert.sv @@
// Sorted unique set, top level: a chain of compare-and-shift cells.
// The result of an item is registered; m_tvalid rises in the cycle after it is accepted.
// One item per cycle unless m_tready stalls; all cells compare and shift in the same cycle.
// An output register holds the result while the next item is taken.
// Reset clears the count and the output valid; stored entries stay undefined.
// Depends on sus_pkg and sus_cell.
`default_nettype none

module sorted_unique_set_insert #(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // value[31:0], rank[36:32], zero fill
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata    // entry_value[31:0], entry_valid[32], inserted[33],
                                        // duplicate[34], full_res[35], count[41:36], zero fill
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > sus_pkg::RANK_W) ? CW : sus_pkg::RANK_W;

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   m_tvalid_reg;
    sus_pkg::result_t       res_reg;
    sus_pkg::result_t       res_next;

    logic                   accept;
    sus_pkg::action_t       act;
    logic [VALUE_BITS-1:0]  key;
    logic [sus_pkg::RANK_W-1:0] rank;
    logic                   commit;
    logic                   dup_any;
    logic                   set_full;
    logic                   rank_ok;

    logic [VALUE_BITS-1:0]  cell_val [CAPACITY];
    sus_pkg::cell_flags_t   cell_flags [CAPACITY];
    logic [CAPACITY-1:0]    eq_vec;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign act      = sus_pkg::action_t'(s_tuser);
    assign key      = VALUE_BITS'(s_tdata[31:0]);
    assign rank     = s_tdata[36:32];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                  left_ge;
            logic [VALUE_BITS-1:0] left_val;

            if (i == 0)
            begin : g_first
                assign left_ge  = 1'b0;
                assign left_val = key;
            end
            else
            begin : g_rest
                assign left_ge  = cell_flags[i-1].ge;
                assign left_val = cell_val[i-1];
            end

            sus_cell #(
                .VALUE_BITS(VALUE_BITS)
            ) u_cell (
                .clk        (clk),
                .occupied   (CW'(i) < count_reg),
                .left_ge    (left_ge),
                .left_val   (left_val),
                .key        (key),
                .shift_en   (commit),
                .stored_val (cell_val[i]),
                .flags      (cell_flags[i])
            );

            assign eq_vec[i] = cell_flags[i].eq;
        end
    endgenerate

    assign dup_any  = |eq_vec;
    assign set_full = (count_reg == CW'(CAPACITY));
    assign commit   = accept && (act == sus_pkg::ACT_INSERT) && !dup_any && !set_full;
    assign rank_ok  = CMPW'(rank) < CMPW'(count_reg);

    always_comb
    begin
        count_next = count_reg;
        res_next   = '0;
        unique case (act)
            sus_pkg::ACT_INSERT:
            begin
                if (dup_any)
                    res_next.duplicate = 1'b1;
                else if (set_full)
                    res_next.full_res = 1'b1;
                else
                begin
                    res_next.inserted = 1'b1;
                    count_next        = count_reg + CW'(1);
                end
            end
            sus_pkg::ACT_CLEAR:
                count_next = '0;
            sus_pkg::ACT_READ:
            begin
                if (rank_ok)
                begin
                    res_next.entry_valid = 1'b1;
                    res_next.entry_value = sus_pkg::VALUE_W'(cell_val[IW'(rank)]);
                end
            end
            default:
                count_next = count_reg;
        endcase
        res_next.count = sus_pkg::COUNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, res_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0({res_reg.inserted, res_reg.duplicate, res_reg.full_res,
                               res_reg.entry_valid}))
        else $error("result flags not mutually exclusive");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not advance the count");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
